FILE: sv/yuv2rgb_pkg.sv
`default_nettype none

package yuv2rgb_pkg;

	localparam int DEF_MAX_WIDTH      = 2048;
	localparam int DEF_COEF_FRAC_BITS = 8;

	localparam int ALPHA_W   = 9;
	localparam int WIDTH_W   = 12;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = WIDTH_W;

	localparam logic [ALPHA_W-1:0] RST_ALPHA = 9'd256;
	localparam logic [WIDTH_W-1:0] RST_WIDTH = 12'd1920;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'd1;

	// front-to-back queue, depth kept a power of two so pointers wrap on their own
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
	} pix_t;

	// floor(c * a / 256), saturated to 255
	function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [ALPHA_W-1:0] a);
		logic [16:0] p;
		p = 17'(c) * 17'(a);
		if (p[16] == 1'b1) begin
			return 8'd255;
		end
		return p[15:8];
	endfunction

	function automatic logic [7:0] sat_alpha(input logic [ALPHA_W-1:0] a);
		if (a[ALPHA_W-1] == 1'b1) begin
			return 8'd255;
		end
		return a[7:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/yuv2rgb_front.sv
`default_nettype none

module yuv2rgb_front #(
	parameter int MAX_WIDTH = yuv2rgb_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [yuv2rgb_pkg::WIDTH_W-1:0]  line_width,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire yuv2rgb_pkg::pix_t                in_pix,
	input  wire logic                             in_first,
	output logic                                  q_valid,
	input  wire logic                             q_ready,
	output yuv2rgb_pkg::pix_t                     q_pix
);
	import yuv2rgb_pkg::*;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int EW         = $clog2(MAX_WIDTH + 1);
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [COL_W-1:0]  col_q;
	logic              odd_q;
	logic [15:0]       cur_q;
	logic              s1_v;
	logic [7:0]        luma_s1;
	logic              sel_mem_s1;
	logic [15:0]       chroma_s1;
	logic [15:0]       rd_q;
	logic [15:0]       line_mem [LINE_DEPTH];

	logic [31:0]       w32;
	logic [EW-1:0]     eff_w;
	logic [COL_W-1:0]  col_base;
	logic              odd_base;
	logic              wrap0;
	logic [COL_W-1:0]  col_cur;
	logic              odd_cur;
	logic [EW-1:0]     col_inc;
	logic              wrap1;
	logic [COL_W-1:0]  col_nxt;
	logic              odd_nxt;
	logic [SLOT_W-1:0] slot;
	logic              load_chroma;
	logic [15:0]       chroma_now;
	logic [15:0]       pair;
	logic              acc;

	// effective row width: clamped to 2..MAX_WIDTH, rounded down to even
	always_comb begin
		w32 = 32'(line_width);
		if (w32 < 32'd2) begin
			w32 = 32'd2;
		end else if (w32 > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end
		w32   = w32 & ~32'd1;
		eff_w = w32[EW-1:0];
	end

	always_comb begin
		col_base    = in_first ? '0 : col_q;
		odd_base    = in_first ? 1'b0 : odd_q;
		// width lowered mid-row: this word opens the next row
		wrap0       = EW'(col_base) >= eff_w;
		col_cur     = wrap0 ? '0 : col_base;
		odd_cur     = odd_base ^ wrap0;
		col_inc     = EW'(col_cur) + EW'(1);
		wrap1       = col_inc >= eff_w;
		col_nxt     = wrap1 ? '0 : col_inc[COL_W-1:0];
		odd_nxt     = odd_cur ^ wrap1;
		slot        = SLOT_W'(col_cur >> 1);
		load_chroma = !odd_cur && !col_cur[0];
		chroma_now  = load_chroma ? {in_pix.cb, in_pix.cr} : cur_q;
	end

	assign acc      = in_valid && in_ready;
	assign in_ready = !s1_v || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
			cur_q <= '0;
			s1_v  <= 1'b0;
		end else begin
			if (acc) begin
				col_q <= col_nxt;
				odd_q <= odd_nxt;
				if (load_chroma) begin
					cur_q <= {in_pix.cb, in_pix.cr};
				end
				s1_v <= 1'b1;
			end else if (q_ready) begin
				s1_v <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			luma_s1    <= in_pix.luma;
			sel_mem_s1 <= odd_cur;
			chroma_s1  <= chroma_now;
		end
	end

	// chroma line buffer: even rows write, odd rows read back
	always_ff @(posedge clk) begin
		if (acc && load_chroma) begin
			line_mem[slot] <= {in_pix.cb, in_pix.cr};
		end
		if (acc && odd_cur) begin
			rd_q <= line_mem[slot];
		end
	end

	assign pair       = sel_mem_s1 ? rd_q : chroma_s1;
	assign q_valid    = s1_v;
	assign q_pix.luma = luma_s1;
	assign q_pix.cb   = pair[15:8];
	assign q_pix.cr   = pair[7:0];

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && !q_ready |=> s1_v)
		else $error("front stage dropped a stalled word");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_first |=> (!odd_q && col_q == COL_W'(1)) || (odd_q && col_q == '0))
		else $error("frame start did not restart the raster position");

endmodule

`default_nettype wire

FILE: sv/yuv2rgb_queue.sv
`default_nettype none

module yuv2rgb_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire yuv2rgb_pkg::pix_t in_pix,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output yuv2rgb_pkg::pix_t      out_pix
);
	import yuv2rgb_pkg::*;

	pix_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = cnt_q != QCNT_W'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_pix   = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= in_pix;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
		else $error("queue count missed a push");

endmodule

`default_nettype wire

FILE: sv/yuv2rgb_back.sv
`default_nettype none

module yuv2rgb_back #(
	parameter int COEF_FRAC_BITS = yuv2rgb_pkg::DEF_COEF_FRAC_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [yuv2rgb_pkg::ALPHA_W-1:0]  alpha_level,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire yuv2rgb_pkg::pix_t                in_pix,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            red,
	output logic [7:0]                            green,
	output logic [7:0]                            blue,
	output logic [7:0]                            alpha_out
);
	import yuv2rgb_pkg::*;

	localparam int F  = COEF_FRAC_BITS;
	localparam int SW = F + 11;

	localparam int K_RV = ((1140 << F) + 500) / 1000;
	localparam int K_GU = ((394 << F) + 500) / 1000;
	localparam int K_GV = ((581 << F) + 500) / 1000;
	localparam int K_BU = ((2032 << F) + 500) / 1000;

	localparam logic signed [SW-1:0] KS_RV = SW'(K_RV);
	localparam logic signed [SW-1:0] KS_GU = SW'(K_GU);
	localparam logic signed [SW-1:0] KS_GV = SW'(K_GV);
	localparam logic signed [SW-1:0] KS_BU = SW'(K_BU);
	localparam logic [SW-1:0]        HALF  = SW'(1) << (F - 1);

	logic signed [8:0]    u_d;
	logic signed [8:0]    v_d;
	logic signed [SW-1:0] y_sc;
	logic signed [SW-1:0] r_sum;
	logic signed [SW-1:0] g_sum;
	logic signed [SW-1:0] b_sum;

	logic                 b1_v;
	logic signed [SW-1:0] r_sum_s1;
	logic signed [SW-1:0] g_sum_s1;
	logic signed [SW-1:0] b_sum_s1;
	logic                 out_v;
	logic                 b1_adv;
	logic                 out_adv;

	// negative gives 0, else round half up and saturate
	function automatic logic [7:0] clamp_ch(input logic signed [SW-1:0] s);
		logic [SW-1:0] rnd;
		logic [SW-1:0] sh;
		if (s < 0) begin
			return 8'd0;
		end
		rnd = SW'(unsigned'(s)) + HALF;
		sh  = rnd >> F;
		if (sh > SW'(255)) begin
			return 8'd255;
		end
		return sh[7:0];
	endfunction

	always_comb begin
		u_d   = $signed({1'b0, in_pix.cb}) - 9'sd128;
		v_d   = $signed({1'b0, in_pix.cr}) - 9'sd128;
		y_sc  = $signed(SW'(in_pix.luma) << F);
		r_sum = y_sc + KS_RV * SW'(v_d);
		g_sum = y_sc - KS_GU * SW'(u_d) - KS_GV * SW'(v_d);
		b_sum = y_sc + KS_BU * SW'(u_d);
	end

	assign out_adv  = !out_v || out_ready;
	assign b1_adv   = !b1_v || out_adv;
	assign in_ready = b1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v  <= 1'b0;
			out_v <= 1'b0;
		end else begin
			if (b1_adv) begin
				b1_v <= in_valid;
			end
			if (out_adv) begin
				out_v <= b1_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && b1_adv) begin
			r_sum_s1 <= r_sum;
			g_sum_s1 <= g_sum;
			b_sum_s1 <= b_sum;
		end
		if (b1_v && out_adv) begin
			red       <= scale_ch(clamp_ch(r_sum_s1), alpha_level);
			green     <= scale_ch(clamp_ch(g_sum_s1), alpha_level);
			blue      <= scale_ch(clamp_ch(b_sum_s1), alpha_level);
			alpha_out <= sat_alpha(alpha_level);
		end
	end

	assign out_valid = out_v;

	a_b1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		b1_v && !out_adv |=> b1_v)
		else $error("sum stage dropped a stalled word");

	a_b1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		b1_v && out_adv |=> out_v)
		else $error("sum stage word lost on its way to the output");

endmodule

`default_nettype wire

FILE: sv/yuv420_to_rgb_pixel_converter_core.sv
// A word accepted on s_* passes through the line-buffer stage, the 2-entry
// queue, the sum stage and the clamp/scale output register on its way to m_*.
// Throughput: one word per clock unless m_tready stalls; per word the front
// does at most one chroma line buffer access (even rows write, odd rows read).
// Reset: row/column position, latched chroma and all valids clear; alpha_level
// resets to 256, line_width to 1920. The chroma line buffer is not cleared.
`default_nettype none

module yuv420_to_rgb_pixel_converter_core #(
	parameter int MAX_WIDTH      = yuv2rgb_pkg::DEF_MAX_WIDTH,
	parameter int COEF_FRAC_BITS = yuv2rgb_pkg::DEF_COEF_FRAC_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [yuv2rgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [yuv2rgb_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [23:0]                        s_tdata,  // luma, cb_sample, cr_sample
	input  wire logic                               s_tuser,  // frame_start
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [31:0]                             m_tdata   // red, green, blue, alpha_out
);
	import yuv2rgb_pkg::*;

	logic [ALPHA_W-1:0] alpha_q;
	logic [WIDTH_W-1:0] width_q;
	pix_t               in_pix;
	pix_t               q_in_pix;
	pix_t               q_out_pix;
	logic               q_in_valid;
	logic               q_in_ready;
	logic               q_out_valid;
	logic               q_out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= RST_ALPHA;
			width_q <= RST_WIDTH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data[ALPHA_W-1:0];
				REG_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
			endcase
		end
	end

	assign in_pix.luma = s_tdata[7:0];
	assign in_pix.cb   = s_tdata[15:8];
	assign in_pix.cr   = s_tdata[23:16];

	yuv2rgb_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_width (width_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_pix     (in_pix),
		.in_first   (s_tuser),
		.q_valid    (q_in_valid),
		.q_ready    (q_in_ready),
		.q_pix      (q_in_pix)
	);

	yuv2rgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_in_valid),
		.in_ready  (q_in_ready),
		.in_pix    (q_in_pix),
		.out_valid (q_out_valid),
		.out_ready (q_out_ready),
		.out_pix   (q_out_pix)
	);

	yuv2rgb_back #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.alpha_level (alpha_q),
		.in_valid    (q_out_valid),
		.in_ready    (q_out_ready),
		.in_pix      (q_out_pix),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.red         (m_tdata[7:0]),
		.green       (m_tdata[15:8]),
		.blue        (m_tdata[23:16]),
		.alpha_out   (m_tdata[31:24])
	);

endmodule

`default_nettype wire

FILE: bench/yuv420_to_rgb_pixel_converter_core_tb.sv
module yuv420_to_rgb_pixel_converter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import yuv2rgb_pkg::*;

	localparam int MAX_W        = DEF_MAX_WIDTH;
	localparam int LINE_SLOTS   = MAX_W / 2;
	localparam int FRAC         = DEF_COEF_FRAC_BITS;
	localparam int K_RV         = (1140 * (1 << FRAC) + 500) / 1000;
	localparam int K_GU         = (394 * (1 << FRAC) + 500) / 1000;
	localparam int K_GV         = (581 * (1 << FRAC) + 500) / 1000;
	localparam int K_BU         = (2032 * (1 << FRAC) + 500) / 1000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
	} rgb_t;

	class pixel_scoreboard;
		logic [ALPHA_W-1:0] alpha;
		logic [WIDTH_W-1:0] width;
		int                 col;
		bit                 odd_row;
		logic [15:0]        held_chroma;
		logic [15:0]        chroma_line [LINE_SLOTS];
		bit                 slot_written [LINE_SLOTS];
		rgb_t               expected_rgb [$];
		int                 errors;

		function new();
			alpha = RST_ALPHA;
			width = RST_WIDTH;
			col = 0;
			odd_row = 1'b0;
			held_chroma = '0;
			errors = 0;
			foreach (slot_written[i]) slot_written[i] = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			if (idx == REG_ALPHA) begin
				alpha = data[ALPHA_W-1:0];
			end else begin
				width = data[WIDTH_W-1:0];
			end
		endfunction

		function int row_width();
			int w;
			w = width;
			if (w < 2) w = 2;
			if (w > MAX_W) w = MAX_W;
			return w & ~1;
		endfunction

		function int pending();
			return expected_rgb.size();
		endfunction

		// would this word land on an odd row over a slot never filled since reset
		function bit hits_unwritten(bit frame_start);
			int c;
			bit odd;
			c = frame_start ? 0 : col;
			odd = frame_start ? 1'b0 : odd_row;
			if (c >= row_width()) begin
				c = 0;
				odd = !odd;
			end
			return odd && !slot_written[(c >> 1) % LINE_SLOTS];
		endfunction

		function int round_clamp(int acc);
			int v;
			if (acc < 0) return 0;
			v = (acc + (1 << (FRAC - 1))) >>> FRAC;
			return (v > 255) ? 255 : v;
		endfunction

		function int alpha_scale(int c);
			int v;
			v = (c * int'(alpha)) >> 8;
			return (v > 255) ? 255 : v;
		endfunction

		function void note_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr,
				bit frame_start);
			int w, slot, y, u, v;
			logic [15:0] pair;
			rgb_t e;
			w = row_width();
			if (frame_start) begin
				col = 0;
				odd_row = 1'b0;
			end
			// width lowered under the current column: wrap to the next row
			if (col >= w) begin
				col = 0;
				odd_row = !odd_row;
			end
			slot = (col >> 1) % LINE_SLOTS;
			if (!odd_row) begin
				if (col % 2 == 0) begin
					held_chroma = {cb, cr};
					chroma_line[slot] = held_chroma;
					slot_written[slot] = 1'b1;
				end
				pair = held_chroma;
			end else begin
				pair = chroma_line[slot];
			end
			y = luma;
			u = int'(pair[15:8]) - 128;
			v = int'(pair[7:0]) - 128;
			e.red = 8'(alpha_scale(round_clamp((y << FRAC) + K_RV * v)));
			e.green = 8'(alpha_scale(round_clamp((y << FRAC) - K_GU * u - K_GV * v)));
			e.blue = 8'(alpha_scale(round_clamp((y << FRAC) + K_BU * u)));
			e.alpha_out = alpha[ALPHA_W-1] ? 8'd255 : alpha[7:0];
			expected_rgb.push_back(e);
			col = col + 1;
			if (col >= w) begin
				col = 0;
				odd_row = !odd_row;
			end
		endfunction

		task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 50) begin
				$display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
			end
		endtask

		task check_rgb(logic [31:0] word);
			rgb_t e;
			if (expected_rgb.size() == 0) begin
				flag_mismatch("unexpected word", word, '0);
				return;
			end
			e = expected_rgb.pop_front();
			if (word[7:0] !== e.red) flag_mismatch("red", word[7:0], e.red);
			if (word[15:8] !== e.green) flag_mismatch("green", word[15:8], e.green);
			if (word[23:16] !== e.blue) flag_mismatch("blue", word[23:16], e.blue);
			if (word[31:24] !== e.alpha_out) flag_mismatch("alpha", word[31:24], e.alpha_out);
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [23:0]          s_tdata;  // luma, cb_sample, cr_sample
	logic                 s_tuser;  // frame_start
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;  // red, green, blue, alpha_out

	pixel_scoreboard sb;
	bit              tx_burst;
	bit              rx_burst;
	int              cycle_cnt = 0;

	yuv420_to_rgb_pixel_converter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("yuv420_to_rgb_pixel_converter_core_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_rgb(m_tdata);
	end

	// output side: random stalls per word, none while rx_burst is set
	initial begin
		int gap;
		m_tready <= 1'b0;
		forever begin
			gap = rx_burst ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(arst_n && m_tvalid)) @(posedge clk);
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input logic [7:0] luma, input logic [7:0] cb,
			input logic [7:0] cr, input bit frame_start);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// never let an odd row read a chroma slot that was not filled
		if (sb.hits_unwritten(frame_start)) frame_start = 1'b1;
		s_tvalid <= 1'b1;
		s_tdata <= {cr, cb, luma};
		s_tuser <= frame_start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_pixel(luma, cb, cr, frame_start);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_sample();
		if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int sent, ph, n, sel;
		logic [ALPHA_W-1:0] a;
		logic [WIDTH_W-1:0] w;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ALPHA;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1920 wide, full alpha
		send_pixel(8'd16, 8'd128, 8'd128, 1'b1);
		send_pixel(8'd235, 8'd90, 8'd240, 1'b0);
		drain();

		cfg_write(REG_WIDTH, 12'd2);
		cfg_write(REG_ALPHA, 12'd256);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);      // odd column, chroma ignored
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);    // odd row reuses the line
		send_pixel(8'd0, 8'd17, 8'd99, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd128, 8'd1, 8'd2, 1'b0);
		send_pixel(8'd255, 8'd3, 8'd4, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd128, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		send_pixel(8'd50, 8'd200, 8'd30, 1'b0);
		send_pixel(8'd60, 8'd10, 8'd10, 1'b1);   // restart mid-row
		drain();

		cfg_write(REG_ALPHA, 12'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd200, 8'd0, 8'd0, 1'b0);
		drain();
		cfg_write(REG_ALPHA, 12'd511);           // above 256: saturates
		send_pixel(8'd200, 8'd60, 8'd180, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		drain();

		// shrink the width under the current column: wraps to the next row
		cfg_write(REG_WIDTH, 12'd8);
		send_pixel(8'd90, 8'd140, 8'd70, 1'b1);
		send_pixel(8'd91, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd92, 8'd30, 8'd220, 1'b0);
		drain();
		cfg_write(REG_WIDTH, 12'd2);
		send_pixel(8'd93, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd94, 8'd0, 8'd0, 1'b0);

		sent = 0;
		for (ph = 0; sent < RANDOM_ITEMS; ph++) begin
			drain();
			sel = (ph < 10) ? ph : $urandom_range(0, 9);
			case (sel)
				0: a = 9'd0;
				1: a = 9'd511;
				2: a = 9'd256;
				3: a = 9'd1;
				4: a = 9'd255;
				5: a = 9'd257;
				default: a = 9'($urandom_range(0, 300));
			endcase
			case (sel)
				0: w = 12'd4095;
				1: w = 12'd0;
				2: w = 12'd2048;
				3: w = 12'd1;
				4: w = 12'd2;
				5: w = 12'($urandom_range(2049, 4094));
				6: w = 12'($urandom_range(1, 31) * 2 + 1);
				default: w = 12'($urandom_range(2, 24));
			endcase
			cfg_write(REG_ALPHA, {3'($urandom_range(0, 7)), a});
			cfg_write(REG_WIDTH, w);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			n = (sb.row_width() >= 256) ? 60 : 110;
			for (int i = 0; i < n; i++) begin
				if (ph == 3 && i == n / 2) drain();
				send_pixel(rand_sample(), rand_sample(), rand_sample(),
					$urandom_range(0, 59) == 0);
				sent++;
			end
		end
		drain();
		repeat (8) @(posedge clk);

		if (sb.errors == 0) begin
			$display("yuv420_to_rgb_pixel_converter_core_tb: clean");
		end else begin
			$display("yuv420_to_rgb_pixel_converter_core_tb: errors");
		end
		$finish;
	end

endmodule
